// ===== src/tct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the TCP connection table.
// No dependencies; every other file imports this package.
package tct_pkg;

    localparam int SLOTS = 16;

    localparam logic [2:0] ST_CLOSED      = 3'd0;
    localparam logic [2:0] ST_SYN_SENT    = 3'd1;
    localparam logic [2:0] ST_ESTABLISHED = 3'd2;
    localparam logic [2:0] ST_LAST_ACK    = 3'd4;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic OP_CONNECT = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    localparam logic CFG_INITIAL_SEQUENCE = 1'b0;
    localparam logic CFG_FIRST_PORT       = 1'b1;

    localparam logic [31:0] RESET_INITIAL_SEQUENCE = 32'h1234_5678;
    localparam logic [15:0] RESET_FIRST_PORT       = 16'd49152;

    typedef struct packed {
        logic        operation;
        logic [31:0] peer_ip_in;
        logic [15:0] peer_port_in;
        logic [15:0] own_port_in;
        logic [31:0] seq_in;
        logic [31:0] ack_in;
        logic [7:0]  flags_in;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] peer_ip;
        logic [15:0] own_port;
        logic [15:0] peer_port;
        logic [31:0] seq_out;
        logic [31:0] ack_out;
        logic [7:0]  flags_out;
        logic        last;
    } t_out_word;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic        go;
        logic        op;
        logic [31:0] ip;
        logic [15:0] pport;
        logic [15:0] oport;
        logic [7:0]  flags;
        logic [15:0] next_port;
        logic [31:0] iseq_p1;
    } t_bcast;

    // Passed from cell to cell: priority flags and the selected slot's data.
    typedef struct packed {
        logic        free_seen;
        logic        hit_seen;
        logic [2:0]  hit_state;
        logic [15:0] hit_own_port;
        logic [31:0] hit_send_seq;
    } t_link;

endpackage

// ===== src/tct_cell.sv =====
`timescale 1ns / 1ps
// One connection slot: state, addressing and send sequence.
// Depends on tct_pkg.
module tct_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tct_pkg::t_bcast i_bc,
    input  tct_pkg::t_link  i_link,
    output tct_pkg::t_link  o_link
);
    import tct_pkg::*;

    logic [2:0]  r_state;
    logic [31:0] r_peer_ip;
    logic [15:0] r_peer_port;
    logic [15:0] r_own_port;
    logic [31:0] r_send_seq;

    logic is_open;
    logic match;
    logic take_free;
    logic take_hit;

    assign is_open   = (r_state != ST_CLOSED);
    assign match     = is_open && (r_own_port == i_bc.oport) &&
                       (r_peer_port == i_bc.pport) && (r_peer_ip == i_bc.ip);
    assign take_free = (i_bc.op == OP_CONNECT) && !i_link.free_seen && !is_open;
    assign take_hit  = (i_bc.op == OP_SEGMENT) && !i_link.hit_seen && match;

    always_comb begin
        o_link           = i_link;
        o_link.free_seen = i_link.free_seen | !is_open;
        o_link.hit_seen  = i_link.hit_seen | match;
        if (take_hit) begin
            o_link.hit_state    = r_state;
            o_link.hit_own_port = r_own_port;
            o_link.hit_send_seq = r_send_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLOSED;
        end else if (i_bc.go && take_free) begin
            r_state <= ST_SYN_SENT;
        end else if (i_bc.go && take_hit) begin
            unique case (r_state)
                ST_SYN_SENT: begin
                    if (((i_bc.flags & FL_SYN) != 8'd0) && ((i_bc.flags & FL_ACK) != 8'd0)) begin
                        r_state <= ST_ESTABLISHED;
                    end
                end
                ST_ESTABLISHED: begin
                    if ((i_bc.flags & FL_FIN) != 8'd0) begin
                        r_state <= ST_LAST_ACK;
                    end
                end
                ST_LAST_ACK: begin
                    if ((i_bc.flags & FL_ACK) != 8'd0) begin
                        r_state <= ST_CLOSED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload, gated by the state above.
    always_ff @(posedge i_clk) begin
        if (i_bc.go && take_free) begin
            r_peer_ip   <= i_bc.ip;
            r_peer_port <= i_bc.pport;
            r_own_port  <= i_bc.next_port;
            r_send_seq  <= i_bc.iseq_p1;
        end else if (i_bc.go && take_hit && (r_state == ST_ESTABLISHED) &&
                     ((i_bc.flags & FL_FIN) != 8'd0)) begin
            r_send_seq <= r_send_seq + 32'd1;
        end
    end

endmodule

// ===== src/tct_row.sv =====
`timescale 1ns / 1ps
// Row of SLOTS connection cells with a lowest-index-first priority chain.
// Depends on tct_pkg and tct_cell.
module tct_row (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tct_pkg::t_bcast i_bc,
    output tct_pkg::t_link  o_link
);
    import tct_pkg::*;

    t_link chain [SLOTS+1];

    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        tct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bc    (i_bc),
            .i_link  (chain[g]),
            .o_link  (chain[g+1])
        );
    end

    assign o_link = chain[SLOTS];

endmodule

// ===== src/tcp_connection_table_top.sv =====
`timescale 1ns / 1ps
// TCP connection table, top level. An input word is registered in its accept cycle and
// resolved against the cell row in the next when the output side is free; the row's
// tuple match is combinational and its slot update is registered at resolve. No new word
// is accepted while one waits in the resolve step. A FIN on an established slot yields
// two output words, the second held in a pending register, and the next item waits in
// the resolve step until that register drains. Depends on tct_pkg and tct_row.
module tcp_connection_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tct_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tct_pkg::t_out_word o_out_word
);
    import tct_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic        r_state;
    t_in_word    r_item;
    logic [31:0] r_iseq;
    logic [15:0] r_next_port;
    logic        r_ovld;
    t_out_word   r_out;
    logic        r_pvld;
    t_out_word   r_pend;

    t_bcast    bc;
    t_link     link;
    logic      can_go;
    logic      go;
    logic      fire_in;
    logic      fire_out;
    logic      n_has0;
    logic      n_has1;
    t_out_word n_res0;
    t_out_word n_res1;
    logic [31:0] seq_p1;
    logic      f_fin;
    logic      f_syn;
    logic      f_ack;

    assign o_in_ready  = (r_state == S_IDLE);
    assign fire_in     = i_in_valid && o_in_ready;
    assign fire_out    = r_ovld && i_out_ready;
    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;

    assign can_go = !r_pvld && (!r_ovld || i_out_ready);
    assign go     = (r_state == S_EXEC) && can_go;
    assign seq_p1 = r_item.seq_in + 32'd1;
    assign f_fin  = (r_item.flags_in & FL_FIN) != 8'd0;
    assign f_syn  = (r_item.flags_in & FL_SYN) != 8'd0;
    assign f_ack  = (r_item.flags_in & FL_ACK) != 8'd0;

    always_comb begin
        bc.go        = go;
        bc.op        = r_item.operation;
        bc.ip        = r_item.peer_ip_in;
        bc.pport     = r_item.peer_port_in;
        bc.oport     = r_item.own_port_in;
        bc.flags     = r_item.flags_in;
        bc.next_port = r_next_port;
        bc.iseq_p1   = r_iseq + 32'd1;
    end

    tct_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bc    (bc),
        .o_link  (link)
    );

    always_comb begin
        n_has0 = 1'b0;
        n_has1 = 1'b0;
        n_res0 = '0;
        n_res0.peer_ip   = r_item.peer_ip_in;
        n_res0.peer_port = r_item.peer_port_in;
        n_res0.last      = 1'b1;
        n_res1 = n_res0;
        if (r_item.operation == OP_CONNECT) begin
            n_has0 = 1'b1;
            if (link.free_seen) begin
                n_res0.own_port  = r_next_port;
                n_res0.seq_out   = r_iseq;
                n_res0.flags_out = FL_SYN;
            end else begin
                n_res0.result_kind = KIND_REFUSED;
            end
        end else if (!link.hit_seen) begin
            // unmatched SYN is answered with RST-ACK
            n_has0           = f_syn;
            n_res0.own_port  = r_item.own_port_in;
            n_res0.ack_out   = seq_p1;
            n_res0.flags_out = FL_RST | FL_ACK;
        end else begin
            n_res0.own_port  = link.hit_own_port;
            n_res0.seq_out   = link.hit_send_seq;
            n_res0.ack_out   = seq_p1;
            n_res0.flags_out = FL_ACK;
            n_res1           = n_res0;
            n_res1.flags_out = FL_FIN | FL_ACK;
            if (link.hit_state == ST_SYN_SENT) begin
                n_has0 = f_syn && f_ack;
            end else if (link.hit_state == ST_ESTABLISHED) begin
                n_has0      = f_fin;
                n_has1      = f_fin;
                n_res0.last = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iseq      <= RESET_INITIAL_SEQUENCE;
            r_next_port <= RESET_FIRST_PORT;
            r_ovld      <= 1'b0;
            r_pvld      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (fire_in) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (can_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_INITIAL_SEQUENCE: r_iseq <= i_cfg_data;
                    CFG_FIRST_PORT:       r_next_port <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end else if (go && (r_item.operation == OP_CONNECT) && link.free_seen) begin
                r_next_port <= r_next_port + 16'd1;
            end

            if (go && n_has0) begin
                r_ovld <= 1'b1;
                r_pvld <= n_has1;
            end else if (fire_out) begin
                r_ovld <= r_pvld;
                r_pvld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_in) begin
            r_item <= i_in_word;
        end
        if (go && n_has0) begin
            r_out  <= n_res0;
            r_pend <= n_res1;
        end else if (fire_out) begin
            r_out <= r_pend;
        end
    end

`ifndef ASSERT_OFF
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvld |-> r_ovld)
        else $error("pending word without output word");

    a_pend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvld |-> !r_out.last)
        else $error("first of two words marked last");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_in |=> (r_state == S_EXEC))
        else $error("accepted word did not reach resolve step");

    a_connect_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && (r_item.operation == OP_CONNECT) && link.free_seen) |=>
        (r_ovld && (r_out.flags_out == FL_SYN) && r_out.last))
        else $error("connect to free slot did not emit SYN");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tcp_connection_table_top: directed and random words
// checked against a behavioral copy of the slot table. Depends on tct_pkg and the RTL.
module tb_top;
    import tct_pkg::*;

    localparam int LIMIT_CYCLES     = 200000;
    localparam int RANDOM_PER_PHASE = 106;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES  = 250;

    // Behavioral copy of the table; expected reply words are queued in accept order.
    class conn_table_tracker;
        logic [2:0]  conn_state    [SLOTS];
        logic [31:0] conn_peer_ip  [SLOTS];
        logic [15:0] conn_peer_port[SLOTS];
        logic [15:0] conn_own_port [SLOTS];
        logic [31:0] conn_snd_nxt  [SLOTS];
        logic [31:0] conn_rcv_nxt  [SLOTS];
        logic [31:0] isn;
        logic [15:0] port_counter;
        t_out_word   replies_due[$];
        int          n_fail;

        function new();
            isn          = RESET_INITIAL_SEQUENCE;
            port_counter = RESET_FIRST_PORT;
            n_fail       = 0;
            for (int i = 0; i < SLOTS; i++) begin
                conn_state[i]     = ST_CLOSED;
                conn_peer_ip[i]   = '0;
                conn_peer_port[i] = '0;
                conn_own_port[i]  = '0;
                conn_snd_nxt[i]   = '0;
                conn_rcv_nxt[i]   = '0;
            end
        endfunction

        function void set_config(logic idx, logic [31:0] data);
            if (idx == CFG_INITIAL_SEQUENCE) begin
                isn = data;
            end else begin
                port_counter = data[15:0];
            end
        endfunction

        function void queue_reply(logic kind, logic [31:0] ip, logic [15:0] own,
                                  logic [15:0] peer, logic [31:0] seq, logic [31:0] ack,
                                  logic [7:0] flags, logic last);
            t_out_word r;
            r.result_kind = kind;
            r.peer_ip     = ip;
            r.own_port    = own;
            r.peer_port   = peer;
            r.seq_out     = seq;
            r.ack_out     = ack;
            r.flags_out   = flags;
            r.last        = last;
            replies_due.push_back(r);
        endfunction

        // Returns 1 when the word produced a reply or changed the table.
        function bit note_request(t_in_word w);
            int hit;
            hit = -1;
            if (w.operation == OP_CONNECT) begin
                for (int i = 0; i < SLOTS && hit < 0; i++)
                    if (conn_state[i] == ST_CLOSED) hit = i;
                if (hit < 0) begin
                    queue_reply(KIND_REFUSED, w.peer_ip_in, 16'd0, w.peer_port_in,
                                32'd0, 32'd0, 8'd0, 1'b1);
                    return 1;
                end
                conn_state[hit]     = ST_SYN_SENT;
                conn_peer_ip[hit]   = w.peer_ip_in;
                conn_peer_port[hit] = w.peer_port_in;
                conn_own_port[hit]  = port_counter;
                conn_snd_nxt[hit]   = isn + 32'd1;
                conn_rcv_nxt[hit]   = '0;
                queue_reply(KIND_SEGMENT, w.peer_ip_in, port_counter, w.peer_port_in,
                            isn, 32'd0, FL_SYN, 1'b1);
                port_counter = port_counter + 16'd1;
                return 1;
            end

            for (int i = 0; i < SLOTS && hit < 0; i++)
                if (conn_state[i] != ST_CLOSED && conn_own_port[i] == w.own_port_in &&
                    conn_peer_port[i] == w.peer_port_in && conn_peer_ip[i] == w.peer_ip_in)
                    hit = i;

            if (hit < 0) begin
                if ((w.flags_in & FL_SYN) == 8'd0) return 0;
                queue_reply(KIND_SEGMENT, w.peer_ip_in, w.own_port_in, w.peer_port_in,
                            32'd0, w.seq_in + 32'd1, FL_RST | FL_ACK, 1'b1);
                return 1;
            end

            case (conn_state[hit])
                ST_SYN_SENT: begin
                    if ((w.flags_in & FL_SYN) != 8'd0 && (w.flags_in & FL_ACK) != 8'd0) begin
                        conn_state[hit]   = ST_ESTABLISHED;
                        conn_rcv_nxt[hit] = w.seq_in + 32'd1;
                        queue_reply(KIND_SEGMENT, w.peer_ip_in, conn_own_port[hit],
                                    w.peer_port_in, conn_snd_nxt[hit], conn_rcv_nxt[hit],
                                    FL_ACK, 1'b1);
                        return 1;
                    end
                end
                ST_ESTABLISHED: begin
                    if ((w.flags_in & FL_FIN) != 8'd0) begin
                        conn_rcv_nxt[hit] = w.seq_in + 32'd1;
                        queue_reply(KIND_SEGMENT, w.peer_ip_in, conn_own_port[hit],
                                    w.peer_port_in, conn_snd_nxt[hit], conn_rcv_nxt[hit],
                                    FL_ACK, 1'b0);
                        queue_reply(KIND_SEGMENT, w.peer_ip_in, conn_own_port[hit],
                                    w.peer_port_in, conn_snd_nxt[hit], conn_rcv_nxt[hit],
                                    FL_FIN | FL_ACK, 1'b1);
                        conn_state[hit]   = ST_LAST_ACK;
                        conn_snd_nxt[hit] = conn_snd_nxt[hit] + 32'd1;
                        return 1;
                    end
                end
                ST_LAST_ACK: begin
                    if ((w.flags_in & FL_ACK) != 8'd0) begin
                        conn_state[hit] = ST_CLOSED;
                        return 1;
                    end
                end
                default: ;
            endcase
            return 0;
        endfunction

        task report(string msg);
            if (n_fail < 100) $display("ERROR %0t: %s", $time, msg);
            n_fail++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s: got %h, expected %h", name, got, want));
        endtask

        task check_reply(t_out_word got);
            t_out_word want;
            if (replies_due.size() == 0) begin
                report($sformatf("reply word with nothing pending: %h", got));
                return;
            end
            want = replies_due.pop_front();
            check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            check_field("peer_ip", got.peer_ip, want.peer_ip);
            check_field("own_port", 32'(got.own_port), 32'(want.own_port));
            check_field("peer_port", 32'(got.peer_port), 32'(want.peer_port));
            check_field("seq_out", got.seq_out, want.seq_out);
            check_field("ack_out", got.ack_out, want.ack_out);
            check_field("flags_out", 32'(got.flags_out), 32'(want.flags_out));
            check_field("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        o_in_ready;
    t_in_word    in_word;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_word   o_out_word;

    conn_table_tracker sb;
    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_left = 0;

    tcp_connection_table_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word (o_out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: long hold-off when requested, random stalls otherwise.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) sb.check_reply(o_out_word);
    end

    task automatic send_word(t_in_word w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct) gap++;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word  = w;
        in_valid = 1'b1;
        do @(posedge clk); while (!o_in_ready);
        void'(sb.note_request(w));
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_config(idx, data);
    endtask

    // Words that make no reply may still be in flight once the queue empties.
    task automatic wait_idle();
        while (sb.replies_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_in_word segment_word(logic [31:0] ip, logic [15:0] pport,
                                              logic [15:0] oport, logic [31:0] seq,
                                              logic [7:0] flags);
        t_in_word w;
        w.operation    = OP_SEGMENT;
        w.peer_ip_in   = ip;
        w.peer_port_in = pport;
        w.own_port_in  = oport;
        w.seq_in       = seq;
        w.ack_in       = $urandom;
        w.flags_in     = flags;
        return w;
    endfunction

    // Own port, sequence and flags are don't-care for a connect; keep them random.
    function automatic t_in_word connect_word(logic [31:0] ip, logic [15:0] pport);
        t_in_word w;
        w           = segment_word(ip, pport, 16'($urandom), $urandom, 8'($urandom));
        w.operation = OP_CONNECT;
        return w;
    endfunction

    function automatic t_in_word slot_word(int idx, logic [7:0] flags, logic [31:0] seq);
        return segment_word(sb.conn_peer_ip[idx], sb.conn_peer_port[idx],
                            sb.conn_own_port[idx], seq, flags);
    endfunction

    function automatic int pick_slot(logic [2:0] want, bit any_open);
        int cand[$];
        for (int i = 0; i < SLOTS; i++)
            if (any_open ? sb.conn_state[i] != ST_CLOSED : sb.conn_state[i] == want)
                cand.push_back(i);
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    // Small pools make repeated peers likely.
    function automatic logic [31:0] pick_ip();
        if ($urandom_range(1)) return $urandom;
        return 32'h0A00_0000 | 32'($urandom_range(3));
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(1)) return 16'($urandom);
        return 16'd8080 + 16'($urandom_range(3));
    endfunction

    function automatic t_in_word next_request();
        int         r;
        int         idx;
        logic [7:0] flags;
        r     = $urandom_range(99);
        idx   = -1;
        flags = 8'($urandom);
        if (r < 30) begin
            return connect_word(pick_ip(), pick_port());
        end else if (r < 50) begin
            idx   = pick_slot(ST_SYN_SENT, 1'b0);
            flags = flags | FL_SYN | FL_ACK;
        end else if (r < 65) begin
            idx   = pick_slot(ST_ESTABLISHED, 1'b0);
            flags = flags | FL_FIN;
        end else if (r < 80) begin
            idx   = pick_slot(ST_LAST_ACK, 1'b0);
            flags = flags | FL_ACK;
        end else if (r < 88) begin
            idx = pick_slot(ST_CLOSED, 1'b1);
        end
        if (idx >= 0) return slot_word(idx, flags, $urandom);
        // noise, nearly always misses the table
        return segment_word(pick_ip(), pick_port(), pick_port(), $urandom, 8'($urandom));
    endfunction

    initial begin : watchdog
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            n_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb       = new();
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_INITIAL_SEQUENCE;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full life of one slot with all-ones peer address and port; the peer sequence wraps on +1.
        send_word(connect_word(32'hFFFF_FFFF, 16'hFFFF));
        send_word(slot_word(0, FL_SYN | FL_ACK, 32'hFFFF_FFFF));
        send_word(slot_word(0, FL_FIN, 32'hFFFF_FFFF));
        send_word(slot_word(0, FL_ACK, 32'h0));
        // Unmatched SYN gets RST-ACK; unmatched plain segment is dropped.
        send_word(segment_word(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        send_word(segment_word(32'h0, 16'h0, 16'h0, 32'h0, 8'h00));
        // Reopen slot 0, then matched words that fit no transition.
        send_word(connect_word(32'h0, 16'h0));
        send_word(slot_word(0, FL_RST, $urandom));
        send_word(slot_word(0, FL_FIN, $urandom));
        send_word(slot_word(0, FL_SYN, $urandom));
        // Fill the table, then one more connect is refused.
        for (int k = 0; k < SLOTS - 1; k++) send_word(connect_word($urandom, 16'($urandom)));
        send_word(connect_word($urandom, 16'($urandom)));
        drop_valid();
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_INITIAL_SEQUENCE, 32'hFFFF_FFFF);
                    write_reg(CFG_FIRST_PORT, {16'($urandom), 16'hFFFF});
                    gap_pct   = 0;
                    stall_pct = 0;
                    @(posedge clk);
                    hold_left = HOLD_OFF_CYCLES;
                end
                1: begin
                    write_reg(CFG_INITIAL_SEQUENCE, 32'h0);
                    write_reg(CFG_FIRST_PORT, {16'($urandom), 16'h0});
                    gap_pct   = 46;
                    stall_pct = 0;
                end
                2: begin
                    write_reg(CFG_INITIAL_SEQUENCE, $urandom);
                    write_reg(CFG_FIRST_PORT, $urandom);
                    gap_pct   = 0;
                    stall_pct = 46;
                end
                default: begin
                    write_reg(CFG_INITIAL_SEQUENCE, $urandom);
                    gap_pct   = 10;
                    stall_pct = 10;
                end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) send_word(next_request());
            drop_valid();
            wait_idle();
        end

        if (sb.n_fail == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/tct_pkg.sv
src/tct_cell.sv
src/tct_row.sv
src/tcp_connection_table_top.sv
dv/tb_top.sv
